// ===== hw/rtl/cle_pkg.sv =====
// Shared types and constants of the console line editor.
package cle_pkg;

  localparam int LINE_DEPTH  = 128;
  localparam int PTR_MOD     = 2 * LINE_DEPTH;
  localparam int PTR_W       = $clog2(PTR_MOD);
  localparam int DIST_W      = PTR_W + 1;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);
  localparam int CHAR_W      = 8;
  localparam int ERASE_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_EOF  = 8'h04;
  localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LIST = 8'h10;
  localparam logic [CHAR_W-1:0] CH_KILL = 8'h15;
  localparam logic [CHAR_W-1:0] CH_DEL  = 8'h7F;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_LIST,
    OP_KILL,
    OP_ERASE,
    OP_APPEND
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              term;
  } item_t;

endpackage

// ===== hw/rtl/cle_front.sv =====
// Front end that classifies each incoming item into an editor operation.
module cle_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [cle_pkg::CHAR_W-1:0] rx_char_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output cle_pkg::item_t             push_item_o
);

  logic [cle_pkg::CHAR_W-1:0] ch;

  assign ch = (rx_char_i == cle_pkg::CH_CR) ? cle_pkg::CH_LF : rx_char_i;

  always_comb begin
    push_item_o.ch   = ch;
    push_item_o.term = (ch == cle_pkg::CH_LF) || (ch == cle_pkg::CH_EOF);
    if (command_i == cle_pkg::CMD_READ) begin
      push_item_o.op = cle_pkg::OP_READ;
    end else if (rx_char_i == cle_pkg::CH_LIST) begin
      push_item_o.op = cle_pkg::OP_LIST;
    end else if (rx_char_i == cle_pkg::CH_KILL) begin
      push_item_o.op = cle_pkg::OP_KILL;
    end else if (rx_char_i == cle_pkg::CH_BS || rx_char_i == cle_pkg::CH_DEL) begin
      push_item_o.op = cle_pkg::OP_ERASE;
    end else if (rx_char_i == cle_pkg::CH_NUL) begin
      push_item_o.op = cle_pkg::OP_NOP;
    end else begin
      push_item_o.op = cle_pkg::OP_APPEND;
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// ===== hw/rtl/cle_queue.sv =====
// Short item queue between the classifying front end and the executing back end.
module cle_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cle_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cle_pkg::item_t pop_item_o
);

  cle_pkg::item_t              entries_q [cle_pkg::QUEUE_DEPTH];
  logic [cle_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [cle_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [cle_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        push, pop;

  assign push_ready_o = (count_q != cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + cle_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + cle_pkg::QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + cle_pkg::QCNT_W'(1);
      2'b01:   count_d = count_q - cle_pkg::QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/cle_back.sv =====
// Back end that edits the line ring, serves reads and holds the result register.
module cle_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  cle_pkg::item_t              item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        echo_valid_o,
  output logic [cle_pkg::CHAR_W-1:0]  echo_char_o,
  output logic [cle_pkg::ERASE_W-1:0] erase_count_o,
  output logic                        line_ready_o,
  output logic                        list_request_o,
  output logic                        read_valid_o,
  output logic [cle_pkg::CHAR_W-1:0]  read_byte_o
);

  function automatic logic [cle_pkg::PTR_W-1:0] ptr_inc(input logic [cle_pkg::PTR_W-1:0] p);
    return (p == cle_pkg::PTR_W'(cle_pkg::PTR_MOD - 1)) ? '0 : p + cle_pkg::PTR_W'(1);
  endfunction

  function automatic logic [cle_pkg::PTR_W-1:0] ptr_dec(input logic [cle_pkg::PTR_W-1:0] p);
    return (p == '0) ? cle_pkg::PTR_W'(cle_pkg::PTR_MOD - 1) : p - cle_pkg::PTR_W'(1);
  endfunction

  function automatic logic [cle_pkg::DIST_W-1:0] ptr_dist(
    input logic [cle_pkg::PTR_W-1:0] hi,
    input logic [cle_pkg::PTR_W-1:0] lo
  );
    logic [cle_pkg::DIST_W-1:0] h, l;
    h = {1'b0, hi};
    l = {1'b0, lo};
    return (hi >= lo) ? h - l : h + cle_pkg::DIST_W'(cle_pkg::PTR_MOD) - l;
  endfunction

  function automatic logic [cle_pkg::ADDR_W-1:0] ptr_slot(input logic [cle_pkg::PTR_W-1:0] p);
    logic [cle_pkg::PTR_W-1:0] s;
    s = (p >= cle_pkg::PTR_W'(cle_pkg::LINE_DEPTH)) ? p - cle_pkg::PTR_W'(cle_pkg::LINE_DEPTH)
                                                    : p;
    return s[cle_pkg::ADDR_W-1:0];
  endfunction

  logic [cle_pkg::CHAR_W-1:0]  mem_q [cle_pkg::LINE_DEPTH];
  logic [cle_pkg::CHAR_W-1:0]  rd_data_q;
  logic [cle_pkg::PTR_W-1:0]   read_ptr_q, read_ptr_d;
  logic [cle_pkg::PTR_W-1:0]   commit_ptr_q, commit_ptr_d;
  logic [cle_pkg::PTR_W-1:0]   edit_ptr_q, edit_ptr_d;
  logic [cle_pkg::PTR_W-1:0]   edit_next;
  logic                        out_valid_q, out_valid_d;
  logic                        echo_valid_q, echo_valid_d;
  logic [cle_pkg::CHAR_W-1:0]  echo_char_q, echo_char_d;
  logic [cle_pkg::ERASE_W-1:0] erase_q, erase_d;
  logic                        line_ready_q, line_ready_d;
  logic                        list_q, list_d;
  logic                        read_valid_q, read_valid_d;
  logic                        slot_free, exec, rd_en, wr_en;

  assign slot_free    = !out_valid_q || out_ready_i;
  assign item_ready_o = slot_free;
  assign exec         = item_valid_i && slot_free;
  assign edit_next    = ptr_inc(edit_ptr_q);

  always_comb begin
    read_ptr_d   = read_ptr_q;
    commit_ptr_d = commit_ptr_q;
    edit_ptr_d   = edit_ptr_q;
    out_valid_d  = slot_free ? item_valid_i : out_valid_q;
    echo_valid_d = 1'b0;
    echo_char_d  = '0;
    erase_d      = '0;
    line_ready_d = 1'b0;
    list_d       = 1'b0;
    read_valid_d = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    if (exec) begin
      case (item_i.op)
        cle_pkg::OP_READ: begin
          if (read_ptr_q != commit_ptr_q) begin
            rd_en        = 1'b1;
            read_valid_d = 1'b1;
            read_ptr_d   = ptr_inc(read_ptr_q);
          end
        end
        cle_pkg::OP_LIST: begin
          list_d = 1'b1;
        end
        cle_pkg::OP_KILL: begin
          erase_d    = cle_pkg::ERASE_W'(ptr_dist(edit_ptr_q, commit_ptr_q));
          edit_ptr_d = commit_ptr_q;
        end
        cle_pkg::OP_ERASE: begin
          if (edit_ptr_q != commit_ptr_q) begin
            edit_ptr_d = ptr_dec(edit_ptr_q);
            erase_d    = cle_pkg::ERASE_W'(1);
          end
        end
        cle_pkg::OP_APPEND: begin
          if (ptr_dist(edit_ptr_q, read_ptr_q) < cle_pkg::DIST_W'(cle_pkg::LINE_DEPTH)) begin
            echo_valid_d = 1'b1;
            echo_char_d  = item_i.ch;
            wr_en        = 1'b1;
            edit_ptr_d   = edit_next;
            if (item_i.term ||
                ptr_dist(edit_next, read_ptr_q) == cle_pkg::DIST_W'(cle_pkg::LINE_DEPTH)) begin
              commit_ptr_d = edit_next;
              line_ready_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_ptr_q   <= '0;
      commit_ptr_q <= '0;
      edit_ptr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      read_ptr_q   <= read_ptr_d;
      commit_ptr_q <= commit_ptr_d;
      edit_ptr_q   <= edit_ptr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      echo_valid_q <= echo_valid_d;
      echo_char_q  <= echo_char_d;
      erase_q      <= erase_d;
      line_ready_q <= line_ready_d;
      list_q       <= list_d;
      read_valid_q <= read_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_slot(edit_ptr_q)] <= item_i.ch;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_slot(read_ptr_q)];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign echo_valid_o   = echo_valid_q;
  assign echo_char_o    = echo_char_q;
  assign erase_count_o  = erase_q;
  assign line_ready_o   = line_ready_q;
  assign list_request_o = list_q;
  assign read_valid_o   = read_valid_q;
  assign read_byte_o    = read_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/console_line_editor.sv =====
// Console line editor top level: front end, item queue and back end.
// An accepted item passes through the item queue into the back end's result register.
// Throughput: one item per cycle, set by the single-port line memory, while out_ready_i does not stall.
// The front end takes a new item while a finished result still waits in the result register,
// until the two-entry item queue is full. Reset clears the ring pointers, the queue and the valid
// flag of the result register; the line memory is not cleared, since only written entries are ever read.
module console_line_editor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [cle_pkg::CHAR_W-1:0]  rx_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        echo_valid_o,
  output logic [cle_pkg::CHAR_W-1:0]  echo_char_o,
  output logic [cle_pkg::ERASE_W-1:0] erase_count_o,
  output logic                        line_ready_o,
  output logic                        list_request_o,
  output logic                        read_valid_o,
  output logic [cle_pkg::CHAR_W-1:0]  read_byte_o
);

  logic           push_valid, push_ready;
  cle_pkg::item_t push_item;
  logic           q_valid, q_ready;
  cle_pkg::item_t q_item;

  cle_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_char_i    (rx_char_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  cle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  cle_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .echo_valid_o   (echo_valid_o),
    .echo_char_o    (echo_char_o),
    .erase_count_o  (erase_count_o),
    .line_ready_o   (line_ready_o),
    .list_request_o (list_request_o),
    .read_valid_o   (read_valid_o),
    .read_byte_o    (read_byte_o)
  );

`ifndef SYNTHESIS
  a_full_queue_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("Input stalled while the item queue is empty.");

  a_pop_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> out_valid_o)
    else $error("Executed item did not produce a result.");

  a_one_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({echo_valid_o, erase_count_o != '0, list_request_o,
                                 read_valid_o}) <= 1))
    else $error("Result carries more than one kind of action.");

  a_commit_with_echo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_ready_o) |-> echo_valid_o)
    else $error("Line committed without an appended character.");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for console_line_editor: random handshakes, scoreboard-checked results.
module testbench;

  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT_TIME  = 2_000_000;

  typedef struct packed {
    logic                        echo_valid;
    logic [cle_pkg::CHAR_W-1:0]  echo_char;
    logic [cle_pkg::ERASE_W-1:0] erase_count;
    logic                        line_ready;
    logic                        list_request;
    logic                        read_valid;
    logic [cle_pkg::CHAR_W-1:0]  read_byte;
  } editor_result_t;

  class line_scoreboard;
    logic [cle_pkg::CHAR_W-1:0] ring [cle_pkg::LINE_DEPTH];
    logic [cle_pkg::PTR_W-1:0]  read_ptr;
    logic [cle_pkg::PTR_W-1:0]  commit_ptr;
    logic [cle_pkg::PTR_W-1:0]  edit_ptr;
    editor_result_t             awaited [$];
    int                         errors;

    function new();
      read_ptr   = '0;
      commit_ptr = '0;
      edit_ptr   = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void note_item(logic cmd, logic [cle_pkg::CHAR_W-1:0] ch);
      editor_result_t            r;
      logic [cle_pkg::PTR_W-1:0] used;
      logic [cle_pkg::PTR_W-1:0] span;
      r = '0;
      used = edit_ptr - read_ptr;
      span = edit_ptr - commit_ptr;
      if (cmd == cle_pkg::CMD_READ) begin
        if (read_ptr != commit_ptr) begin
          r.read_valid = 1'b1;
          r.read_byte  = ring[read_ptr[cle_pkg::ADDR_W-1:0]];
          read_ptr     = read_ptr + 1'b1;
        end
      end else if (ch == cle_pkg::CH_LIST) begin
        r.list_request = 1'b1;
      end else if (ch == cle_pkg::CH_KILL) begin
        r.erase_count = cle_pkg::ERASE_W'(span);
        edit_ptr      = commit_ptr;
      end else if (ch == cle_pkg::CH_BS || ch == cle_pkg::CH_DEL) begin
        if (span != 0) begin
          edit_ptr      = edit_ptr - 1'b1;
          r.erase_count = cle_pkg::ERASE_W'(1);
        end
      end else if (ch != cle_pkg::CH_NUL && used < cle_pkg::LINE_DEPTH) begin
        if (ch == cle_pkg::CH_CR) ch = cle_pkg::CH_LF;
        r.echo_valid = 1'b1;
        r.echo_char  = ch;
        ring[edit_ptr[cle_pkg::ADDR_W-1:0]] = ch;
        edit_ptr = edit_ptr + 1'b1;
        used     = edit_ptr - read_ptr;
        if (ch == cle_pkg::CH_LF || ch == cle_pkg::CH_EOF || used == cle_pkg::LINE_DEPTH) begin
          commit_ptr   = edit_ptr;
          r.line_ready = 1'b1;
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(editor_result_t act);
      editor_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, act);
        return;
      end
      want = awaited.pop_front();
      check_field("echo_valid", want.echo_valid, act.echo_valid);
      check_field("echo_char", want.echo_char, act.echo_char);
      check_field("erase_count", want.erase_count, act.erase_count);
      check_field("line_ready", want.line_ready, act.line_ready);
      check_field("list_request", want.list_request, act.list_request);
      check_field("read_valid", want.read_valid, act.read_valid);
      check_field("read_byte", want.read_byte, act.read_byte);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        command = cle_pkg::CMD_RX;
  logic [cle_pkg::CHAR_W-1:0]  rx_char = cle_pkg::CH_NUL;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        echo_valid;
  logic [cle_pkg::CHAR_W-1:0]  echo_char;
  logic [cle_pkg::ERASE_W-1:0] erase_count;
  logic                        line_ready;
  logic                        list_request;
  logic                        read_valid;
  logic [cle_pkg::CHAR_W-1:0]  read_byte;

  int  in_idle_pct = 34;
  int  out_idle_pct = 34;
  bit  hold_req = 1'b0;

  line_scoreboard sb = new();

  console_line_editor DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .rx_char_i      (rx_char),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .echo_valid_o   (echo_valid),
    .echo_char_o    (echo_char),
    .erase_count_o  (erase_count),
    .line_ready_o   (line_ready),
    .list_request_o (list_request),
    .read_valid_o   (read_valid),
    .read_byte_o    (read_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(command, rx_char);
      if (out_valid && out_ready) begin
        sb.check_result({echo_valid, echo_char, erase_count, line_ready,
                         list_request, read_valid, read_byte});
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [cle_pkg::CHAR_W-1:0] ch);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_char  <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_char(input logic [cle_pkg::CHAR_W-1:0] ch);
    send_item(cle_pkg::CMD_RX, ch);
  endtask

  task automatic send_read();
    send_item(cle_pkg::CMD_READ, cle_pkg::CHAR_W'($urandom_range(255)));
  endtask

  function automatic logic [cle_pkg::CHAR_W-1:0] plain_char();
    if ($urandom_range(1) == 0) return cle_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
    return cle_pkg::CHAR_W'($urandom_range(8'h80, 8'hFF));
  endfunction

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_char(cle_pkg::CHAR_W'($urandom_range(255)));
    end else if (pick < 50) begin
      case ($urandom_range(2))
        0: send_char(cle_pkg::CH_LF);
        1: send_char(cle_pkg::CH_CR);
        default: send_char(cle_pkg::CH_EOF);
      endcase
    end else if (pick < 58) begin
      send_char(($urandom_range(1) == 0) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
    end else if (pick < 61) begin
      send_char(cle_pkg::CH_KILL);
    end else if (pick < 64) begin
      send_char(cle_pkg::CH_LIST);
    end else if (pick < 66) begin
      send_char(cle_pkg::CH_NUL);
    end else begin
      send_read();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_read();
    send_char(cle_pkg::CH_BS);
    send_char(cle_pkg::CH_DEL);
    send_char(cle_pkg::CH_KILL);
    send_char(cle_pkg::CH_NUL);
    send_char(cle_pkg::CH_LIST);
    send_char(8'h61);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(cle_pkg::CH_BS);
    send_char(cle_pkg::CH_DEL);
    send_char(8'h01);
    send_char(cle_pkg::CH_KILL);
    send_char(8'h7E);
    send_char(cle_pkg::CH_CR);
    send_char(cle_pkg::CH_EOF);
    send_char(cle_pkg::CH_LF);
    repeat (5) send_read();
    send_char(cle_pkg::CH_BS);

    // Back-to-back traffic: erase a maximal line, then fill the ring.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_char(cle_pkg::CH_KILL);
    repeat (2) send_read();
    repeat (cle_pkg::LINE_DEPTH - 1) send_char(plain_char());
    send_char(cle_pkg::CH_KILL);
    repeat (cle_pkg::LINE_DEPTH) send_char(plain_char());
    repeat (2) send_char(plain_char());
    send_char(cle_pkg::CH_CR);
    send_char(cle_pkg::CH_BS);

    in_idle_pct  = 34;
    out_idle_pct = 34;
    hold_req = 1'b1;
    repeat (120) send_random_item();
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
